@@ rtl/sawlc_pkg.sv @@
// ----------------------------------------------------------------------------
// sawlc_pkg
// Shared types and constants of the write-back LRU cache timing block:
// geometry limits, opcodes, register indexes, cost figures and row layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package sawlc_pkg;

  // geometry limits
  localparam int MAX_SETS     = 1024;
  localparam int MAX_WAYS     = 8;
  localparam int MAX_SET_BITS = $clog2(MAX_SETS);
  localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W       = WAY_W;
  localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
  localparam int TAG_W        = 30;

  // field widths
  localparam int OPCODE_W  = 2;
  localparam int OPERAND_W = 32;
  localparam int SVC_W     = 8;
  localparam int BUS_W     = 9;
  localparam int CNT_W     = 64;
  localparam int RES_W     = 1 + 1 + SVC_W + BUS_W + 8 * CNT_W;
  localparam int OUT_W     = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD   = OUT_W - RES_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_t;

  localparam logic [3:0] RST_SET_BITS   = 4'd6;
  localparam logic [2:0] RST_BLOCK_BITS = 3'd5;
  localparam logic [3:0] RST_WAYS       = 4'd2;
  localparam logic [2:0] MIN_BLOCK_BITS = 3'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_STORE    = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  // cost figures
  localparam logic [SVC_W-1:0] HIT_COST       = 8'd1;
  localparam logic [SVC_W-1:0] FETCH_COST     = 8'd100;
  localparam logic [SVC_W-1:0] WRITEBACK_COST = 8'd100;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0]             dirty;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
  } meta_row_t;

endpackage : sawlc_pkg

`default_nettype wire

@@ rtl/set_assoc_writeback_lru_cache_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache_top
// Timing model of a write-back, write-allocate, set-associative LRU cache,
// fed one load, store or compute gap per request, returning running totals.
// ----------------------------------------------------------------------------
// A request is handled in order: accept and issue the set read, compare the
// ways of the set, write the updated set back and bump the totals, then load
// the result register once the result side is free. A single read-modify-write
// pass over the set memories serves each request; a new request is taken only
// after the previous set has been written back, so no two accesses ever overlap
// on one set. After reset the block sweeps the line state memory once, one set
// per cycle over all 1024 sets, and takes no request until that sweep is done;
// configuration writes are taken at any time.
// Geometry registers may be changed only while the block is idle.
`default_nettype none

module set_assoc_writeback_lru_cache_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request side
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [sawlc_pkg::OPERAND_W-1:0]      s_tdata,  // [31:0] operand_value
  input  wire logic [sawlc_pkg::OPCODE_W-1:0]       s_tuser,  // [1:0] opcode
  // result side
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // m_tdata from bit 0 up: is_hit, did_writeback, service_cycles[8],
  // access_bus_bytes[9], then 64-bit totals: exec time, idle time, compute
  // time, hit_count, miss_count, load_count, store_count, bus_bytes_total,
  // zero pad
  output logic [sawlc_pkg::OUT_W-1:0]               m_tdata,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sawlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sawlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import sawlc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_RESP
  } state_t;

  state_t state;

  // geometry registers
  logic [3:0] set_bits_cfg;
  logic [2:0] block_bits_cfg;
  logic [3:0] ways_cfg;

  // request held for the duration of the access
  opcode_t              op_q;
  logic [OPERAND_W-1:0] val_q;
  logic [SET_W-1:0]     set_q;
  tag_t                 tag_q;
  logic [WCNT_W-1:0]    ways_q;
  logic [2:0]           bb_q;

  // lookup results
  logic             hit_q;
  logic [WAY_W-1:0] way_q;

  // per-access result fields
  logic             res_hit;
  logic             res_wb;
  logic [SVC_W-1:0] res_svc;
  logic [BUS_W-1:0] res_bus;

  // running totals
  logic [CNT_W-1:0] exec_total;
  logic [CNT_W-1:0] idle_total;
  logic [CNT_W-1:0] compute_total;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] loads_total;
  logic [CNT_W-1:0] stores_total;
  logic [CNT_W-1:0] bus_total;

  // clearing sweep
  logic [SET_W-1:0] clr_idx;

  // set memories: tags are never cleared, line state is swept after reset
  tag_row_t  tag_mem  [MAX_SETS];
  meta_row_t meta_mem [MAX_SETS];
  tag_row_t  tag_rd;
  meta_row_t meta_rd;

  logic      mem_re;
  logic      tag_we;
  logic      meta_we;
  tag_row_t  tag_wdata;
  meta_row_t meta_wdata;
  logic [SET_W-1:0] meta_waddr;

  // request decode
  logic [3:0]        eff_sb;
  logic [2:0]        eff_bb;
  logic [WCNT_W-1:0] eff_n;
  logic [OPERAND_W-1:0] block_addr;
  logic [OPERAND_W-1:0] tag_shift;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  rd_set;
  tag_t              rd_tag;

  // lookup logic
  logic [MAX_WAYS-1:0] in_use;
  logic                any_hit;
  logic [WAY_W-1:0]    hit_way;
  logic                any_free;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    lru_way;

  // update logic
  logic              is_access;
  logic              is_store;
  logic              victim_wb;
  logic [RANK_W-1:0] touch_rank;
  logic [SVC_W-1:0]  svc_val;
  logic [BUS_W-1:0]  blk_size;
  logic [BUS_W-1:0]  bus_val;
  meta_row_t         meta_upd;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign mem_re    = s_tvalid && s_tready;

  // geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_cfg   <= RST_SET_BITS;
      block_bits_cfg <= RST_BLOCK_BITS;
      ways_cfg       <= RST_WAYS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_SET_BITS:   set_bits_cfg   <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_cfg <= cfg_data[2:0];
        CFG_WAYS:       ways_cfg       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective geometry and address split
  always_comb begin
    if ({1'b0, set_bits_cfg} > 5'(MAX_SET_BITS)) begin
      eff_sb = 4'(MAX_SET_BITS);
    end else begin
      eff_sb = set_bits_cfg;
    end
    eff_bb = (block_bits_cfg < MIN_BLOCK_BITS) ? MIN_BLOCK_BITS : block_bits_cfg;
    if (ways_cfg == 4'd0) begin
      eff_n = WCNT_W'(1);
    end else if ({1'b0, ways_cfg} > 5'(MAX_WAYS)) begin
      eff_n = WCNT_W'(MAX_WAYS);
    end else begin
      eff_n = WCNT_W'(ways_cfg);
    end
    block_addr = s_tdata >> eff_bb;
    tag_shift  = block_addr >> eff_sb;
    set_mask   = ~({SET_W{1'b1}} << eff_sb);
    rd_set     = block_addr[SET_W-1:0] & set_mask;
    rd_tag     = tag_shift[TAG_W-1:0];
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[set_q] <= tag_wdata;
    end
    if (mem_re) begin
      tag_rd <= tag_mem[rd_set];
    end
  end

  // line state memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (mem_re) begin
      meta_rd <= meta_mem[rd_set];
    end
  end

  // way compare, free way and lru victim
  always_comb begin
    any_hit  = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    lru_way  = '0;
    for (int v = 0; v < MAX_WAYS; v++) begin
      in_use[v] = (WCNT_W'(v) < ways_q);
    end
    for (int v = MAX_WAYS - 1; v >= 0; v--) begin
      if (in_use[v] && meta_rd.valid[v] && (tag_rd[v] == tag_q)) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(v);
      end
      if (in_use[v] && !meta_rd.valid[v]) begin
        any_free = 1'b1;
        free_way = WAY_W'(v);
      end
    end
    // oldest rank wins, lowest way on ties
    for (int v = 1; v < MAX_WAYS; v++) begin
      if (in_use[v] && (meta_rd.rank[v] > meta_rd.rank[lru_way])) begin
        lru_way = WAY_W'(v);
      end
    end
  end

  // set update for the chosen way
  always_comb begin
    is_access  = (op_q == OP_LOAD) || (op_q == OP_STORE);
    is_store   = (op_q == OP_STORE);
    victim_wb  = !hit_q && meta_rd.valid[way_q] && meta_rd.dirty[way_q];
    touch_rank = meta_rd.valid[way_q] ? meta_rd.rank[way_q]
                                      : RANK_W'(ways_q - WCNT_W'(1));
    meta_upd   = meta_rd;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if ((WAY_W'(v) != way_q) && in_use[v] && meta_rd.valid[v] &&
          (meta_rd.rank[v] < touch_rank)) begin
        meta_upd.rank[v] = meta_rd.rank[v] + RANK_W'(1);
      end
    end
    meta_upd.rank[way_q] = '0;
    if (hit_q) begin
      meta_upd.dirty[way_q] = meta_rd.dirty[way_q] | is_store;
    end else begin
      meta_upd.valid[way_q] = 1'b1;
      meta_upd.dirty[way_q] = is_store;
    end

    tag_wdata        = tag_rd;
    tag_wdata[way_q] = tag_q;

    blk_size = BUS_W'(1) << bb_q;
    if (hit_q) begin
      svc_val = HIT_COST;
      bus_val = '0;
    end else if (victim_wb) begin
      svc_val = HIT_COST + FETCH_COST + WRITEBACK_COST;
      bus_val = blk_size << 1;
    end else begin
      svc_val = HIT_COST + FETCH_COST;
      bus_val = blk_size;
    end
  end

  // write ports: the sweep owns the line state memory until it finishes
  assign meta_we    = (state == ST_CLEAR) || ((state == ST_CALC) && is_access);
  assign meta_waddr = (state == ST_CLEAR) ? clr_idx : set_q;
  assign meta_wdata = (state == ST_CLEAR) ? meta_row_t'('0) : meta_upd;
  assign tag_we     = (state == ST_CALC) && is_access && !hit_q;

  // sequencer, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      m_tvalid      <= 1'b0;
      exec_total    <= '0;
      idle_total    <= '0;
      compute_total <= '0;
      hits_total    <= '0;
      misses_total  <= '0;
      loads_total   <= '0;
      stores_total  <= '0;
      bus_total     <= '0;
    end else begin
      // the result state reloads the register itself
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_W'(MAX_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            op_q   <= opcode_t'(s_tuser);
            val_q  <= s_tdata;
            set_q  <= rd_set;
            tag_q  <= rd_tag;
            ways_q <= eff_n;
            bb_q   <= eff_bb;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          hit_q <= any_hit;
          if (any_hit) begin
            way_q <= hit_way;
          end else if (any_free) begin
            way_q <= free_way;
          end else begin
            way_q <= lru_way;
          end
          state <= ST_CALC;
        end
        ST_CALC: begin
          case (op_q)
            OP_LOAD, OP_STORE: begin
              if (is_store) begin
                stores_total <= stores_total + CNT_W'(1);
              end else begin
                loads_total <= loads_total + CNT_W'(1);
              end
              res_hit    <= hit_q;
              res_wb     <= victim_wb;
              res_svc    <= svc_val;
              res_bus    <= bus_val;
              exec_total <= exec_total + CNT_W'(svc_val);
              if (hit_q) begin
                hits_total <= hits_total + CNT_W'(1);
              end else begin
                misses_total <= misses_total + CNT_W'(1);
                idle_total   <= idle_total + CNT_W'(svc_val - HIT_COST);
                bus_total    <= bus_total + CNT_W'(bus_val);
              end
            end
            OP_COMPUTE: begin
              res_hit       <= 1'b0;
              res_wb        <= 1'b0;
              res_svc       <= '0;
              res_bus       <= '0;
              exec_total    <= exec_total + CNT_W'(val_q);
              compute_total <= compute_total + CNT_W'(val_q);
            end
            default: begin
              res_hit <= 1'b0;
              res_wb  <= 1'b0;
              res_svc <= '0;
              res_bus <= '0;
            end
          endcase
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{OUT_PAD{1'b0}}, bus_total, stores_total, loads_total,
                         misses_total, hits_total, compute_total, idle_total,
                         exec_total, res_bus, res_svc, res_wb, res_hit};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // no request may slip in while the line state sweep is still running
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("request accepted during line state sweep");

  // a hit never moves bus data nor writes back
  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RESP) && res_hit) |->
      ((res_svc == HIT_COST) && (res_bus == '0) && !res_wb))
    else $error("hit result carries miss figures");

  // a miss fill always leaves the chosen way valid and most recent
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CALC) && is_access && !hit_q) |->
      (meta_wdata.valid[way_q] && (meta_wdata.rank[way_q] == '0)))
    else $error("filled way not valid or not most recent");

  // the chosen way lies inside the ways in use
  a_way_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> (WCNT_W'(way_q) < ways_q))
    else $error("chosen way beyond ways in use");

  // a writeback result charges the dirty eviction cost
  a_wb_cost: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RESP) && res_wb) |->
      (res_svc == (HIT_COST + FETCH_COST + WRITEBACK_COST)))
    else $error("writeback without its cost");
`endif

endmodule : set_assoc_writeback_lru_cache_top

`default_nettype wire
